FILE: src/gcwr_pkg.sv
package gcwr_pkg;

   localparam int VECTOR_BITS_DEF = 64;
   localparam int MAX_ROWS_DEF    = 64;
   localparam int FIELD_BITS      = 64;
   localparam int WEIGHT_BITS     = 7;
   localparam int SLOT_BITS       = 6;
   localparam int CSR_BITS        = 7;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_REDUCE = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [SLOT_BITS-1:0]  row_slot;
      logic [FIELD_BITS-1:0] row_bits;
      logic [FIELD_BITS-1:0] error_bits;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0]  reduced_bits;
      logic [WEIGHT_BITS-1:0] reduced_weight;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // write the request's row into the store
      logic init;     // load the work vector from the request
      logic rd_en;    // read one row for a compare beat
      logic rd_last;  // that row closes the pass
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic beat_last;  // the closing compare beat of a pass is in progress
      logic pass_more;  // the pass improved the vector at least once
   } dp_status_type;

   // adder tree over 64 bits, six levels
   function automatic logic [WEIGHT_BITS-1:0] popcount(input logic [FIELD_BITS-1:0] v);
      logic [WEIGHT_BITS-1:0] s [FIELD_BITS];
      for (int i = 0; i < FIELD_BITS; i++) begin
         s[i] = WEIGHT_BITS'(v[i]);
      end
      for (int lvl = 0; lvl < 6; lvl++) begin
         for (int i = 0; i < FIELD_BITS / 2; i++) begin
            if (i < ((FIELD_BITS / 2) >> lvl)) begin
               s[i] = s[2*i] + s[2*i+1];
            end
         end
      end
      return s[0];
   endfunction

endpackage

FILE: src/gcwr_datapath.sv
module gcwr_datapath #(
   parameter int VECTOR_BITS = gcwr_pkg::VECTOR_BITS_DEF,
   parameter int MAX_ROWS    = gcwr_pkg::MAX_ROWS_DEF,
   parameter int AW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gcwr_pkg::ctrl_cmd_type cmd,
   input  logic [AW-1:0]          rd_addr,
   input  gcwr_pkg::req_word_type req_word,
   output gcwr_pkg::dp_status_type status,
   output gcwr_pkg::rsp_word_type rsp_word
);
   import gcwr_pkg::*;

   localparam int WW = $clog2(VECTOR_BITS + 1);

   logic [VECTOR_BITS-1:0] gen_mem [MAX_ROWS];
   logic [VECTOR_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_last_ff;
   logic [VECTOR_BITS-1:0] work_ff;
   logic [VECTOR_BITS-1:0] work_in;
   logic [WW-1:0]          weight_ff;
   logic [WW-1:0]          weight_in;
   logic                   changed_ff;
   logic                   changed_in;

   logic [31:0]            slot_ext;
   logic                   slot_ok;
   logic [VECTOR_BITS-1:0] trial;
   logic [FIELD_BITS-1:0]  trial_ext;
   logic [FIELD_BITS-1:0]  error_ext;
   logic [FIELD_BITS-1:0]  work_ext;
   logic [WEIGHT_BITS-1:0] trial_pc;
   logic [WEIGHT_BITS-1:0] error_pc;
   logic                   improve;

   assign slot_ext = 32'(req_word.row_slot);
   assign slot_ok  = slot_ext < 32'(MAX_ROWS);

   // row store: one write port for loads, one registered read port for beats
   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok) begin
         gen_mem[slot_ext[AW-1:0]] <= req_word.row_bits[VECTOR_BITS-1:0];
      end
      if (cmd.rd_en) begin
         rd_data_ff <= gen_mem[rd_addr];
      end
   end

   always_comb begin
      trial     = work_ff ^ rd_data_ff;
      trial_ext = '0;
      trial_ext[VECTOR_BITS-1:0] = trial;
      error_ext = '0;
      error_ext[VECTOR_BITS-1:0] = req_word.error_bits[VECTOR_BITS-1:0];
      work_ext  = '0;
      work_ext[VECTOR_BITS-1:0] = work_ff;
      trial_pc  = popcount(trial_ext);
      error_pc  = popcount(error_ext);
      improve   = rd_valid_ff && (trial_pc[WW-1:0] < weight_ff);

      work_in    = work_ff;
      weight_in  = weight_ff;
      changed_in = changed_ff;
      if (cmd.init) begin
         work_in    = req_word.error_bits[VECTOR_BITS-1:0];
         weight_in  = error_pc[WW-1:0];
         changed_in = 1'b0;
      end else begin
         if (improve) begin
            work_in   = trial;
            weight_in = trial_pc[WW-1:0];
         end
         // drop the flag at the end of each pass
         if (rd_valid_ff && rd_last_ff) begin
            changed_in = 1'b0;
         end else if (improve) begin
            changed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
         work_ff     <= '0;
         weight_ff   <= '0;
         changed_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
         rd_last_ff  <= cmd.rd_last;
         work_ff     <= work_in;
         weight_ff   <= weight_in;
         changed_ff  <= changed_in;
      end
   end

   assign status.beat_last = rd_valid_ff && rd_last_ff;
   assign status.pass_more = changed_ff || improve;

   assign rsp_word.reduced_bits   = work_ext;
   assign rsp_word.reduced_weight = WEIGHT_BITS'(weight_ff);

endmodule

FILE: src/gcwr_controller.sv
module gcwr_controller #(
   parameter int MAX_ROWS = gcwr_pkg::MAX_ROWS_DEF,
   parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            req_cmd,
   input  logic                            csr_write_en,
   input  logic [gcwr_pkg::CSR_BITS-1:0]   csr_write_data,
   input  gcwr_pkg::dp_status_type         status,
   output gcwr_pkg::ctrl_cmd_type          cmd,
   output logic [AW-1:0]                   rd_addr,
   output logic                            busy,
   output logic                            rsp_strobe
);
   import gcwr_pkg::*;

   localparam int RCW = $clog2(MAX_ROWS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type           state_ff;
   logic [AW-1:0]       ptr_ff;
   logic                strobe_ff;
   logic [CSR_BITS-1:0] active_rows_ff;

   logic [31:0]         rows_wide;
   logic [RCW-1:0]      rows_eff;
   logic                ptr_last;
   logic                accept;

   // clamp the row count to the store depth
   assign rows_wide = (32'(active_rows_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                            : 32'(active_rows_ff);
   assign rows_eff  = rows_wide[RCW-1:0];
   assign ptr_last  = (RCW'(ptr_ff) + RCW'(1)) == rows_eff;
   assign accept    = start && (state_ff == ST_IDLE);

   always_comb begin
      cmd.load    = accept && (req_cmd == CMD_LOAD);
      cmd.init    = accept && (req_cmd == CMD_REDUCE);
      cmd.rd_en   = state_ff == ST_SCAN;
      cmd.rd_last = (state_ff == ST_SCAN) && ptr_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ptr_ff         <= '0;
         strobe_ff      <= 1'b0;
         active_rows_ff <= '0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_write_en) begin
            active_rows_ff <= csr_write_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_REDUCE)) begin
                  ptr_ff <= '0;
                  if (rows_eff == '0) begin
                     strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (ptr_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  ptr_ff <= AW'(ptr_ff + 1'b1);
               end
            end
            ST_DRAIN: begin
               // closing beat decides: another pass or done
               if (status.beat_last && status.pass_more) begin
                  ptr_ff   <= '0;
                  state_ff <= ST_SCAN;
               end else begin
                  strobe_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rd_addr    = ptr_ff;
   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;

endmodule

FILE: src/greedy_cycle_weight_reducer.sv
// Greedy cycle weight reducer.
// Request channel: present req_word with start high; the word is taken at a
// clock edge where start is high and busy is low. cmd LOAD writes row_bits into
// store slot row_slot (slots at or past MAX_ROWS are dropped); cmd REDUCE brings
// error_bits to be reduced against the first active_rows rows of the store.
// Config: csr_write_en/csr_write_data write active_rows; write only while idle.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_word
// holding the reduced vector and its weight. The receiver cannot stall; take
// the word in that cycle.
// Timing: busy stays low for a load. A reduce runs passes over the first R
// rows (R = active rows clamped to MAX_ROWS), one row compared per cycle from
// the store's registered read port, each pass closed by a drain state.
// Passes repeat until one makes no change; each change lowers the weight, so
// at most VECTOR_BITS+1 passes run; if R is 0 none runs and busy stays low.
// The next request may be taken in the cycle the strobe is shown.
// Reset: synchronous, clears the controller and active_rows; the row store is
// not cleared, so reduce only against rows that were loaded.
module greedy_cycle_weight_reducer #(
   parameter int VECTOR_BITS = gcwr_pkg::VECTOR_BITS_DEF,
   parameter int MAX_ROWS    = gcwr_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  gcwr_pkg::req_word_type        req_word,
   output logic                          rsp_strobe,
   output gcwr_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_write_en,
   input  logic [gcwr_pkg::CSR_BITS-1:0] csr_write_data
);
   import gcwr_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic [AW-1:0] rd_addr;

   // sequencer: pass and row pointer, config register, response strobe
   gcwr_controller #(
      .MAX_ROWS (MAX_ROWS),
      .AW       (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_cmd        (req_word.cmd),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .status         (dp_status),
      .cmd            (ctrl_cmd),
      .rd_addr        (rd_addr),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe)
   );

   // row store, work vector, XOR and popcount compare
   gcwr_datapath #(
      .VECTOR_BITS (VECTOR_BITS),
      .MAX_ROWS    (MAX_ROWS),
      .AW          (AW)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ctrl_cmd),
      .rd_addr  (rd_addr),
      .req_word (req_word),
      .status   (dp_status),
      .rsp_word (rsp_word)
   );

endmodule

FILE: src/gcwr_checker.sv
module gcwr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input gcwr_pkg::req_word_type req_word,
   input logic                   rsp_strobe,
   input gcwr_pkg::rsp_word_type rsp_word
);
   import gcwr_pkg::*;

   // a response word goes out only while idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // a load never makes the block busy
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.cmd == CMD_LOAD) |=> !busy)
      else $error("load raised busy");

   // the weight matches the vector
   a_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_word.reduced_weight) == $countones(rsp_word.reduced_bits)))
      else $error("weight does not match vector");

   // a reduce ends only with its response
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a response");

endmodule

bind greedy_cycle_weight_reducer gcwr_checker u_gcwr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcwr_pkg::*;

   localparam int VEC_BITS  = VECTOR_BITS_DEF;
   localparam int ROW_COUNT = MAX_ROWS_DEF;
   // Slowest legal reduce is 65 passes over all 64 rows; allow about 250 words
   // at that cost plus sender gaps, then four times over.
   localparam int LIMIT_CYCLES = 250 * ((VEC_BITS + 1) * (ROW_COUNT + 1) + 1 + 40) * 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_word_type        req_word = '0;
   logic                rsp_strobe;
   rsp_word_type        rsp_word;
   logic                csr_write_en = 1'b0;
   logic [CSR_BITS-1:0] csr_write_data = '0;

   greedy_cycle_weight_reducer uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Words waiting for the driver, and reductions waiting for the block.
   req_word_type cmd_queue[$];
   rsp_word_type reduction_queue[$];

   // Predictor copy of the row store and of active_rows.
   logic [VEC_BITS-1:0] model_rows [ROW_COUNT];
   int unsigned         model_active_rows = 0;

   // What the stimulus side knows has been queued (in acceptance order).
   logic [VEC_BITS-1:0] plan_rows [ROW_COUNT];
   bit                  plan_loaded [ROW_COUNT];

   bit took = 1'b0;          // word accepted at the last rising edge
   bit steady_run = 1'b0;    // no random idle gaps from the sender while set
   int cycle_count = 0;
   int mismatch_count = 0;
   int load_count = 0;
   int reduce_count = 0;
   int result_count = 0;
   int setting_count = 0;

   function automatic int ones_count(input logic [VEC_BITS-1:0] v);
      int n;
      n = 0;
      for (int i = 0; i < VEC_BITS; i++) begin
         n += v[i];
      end
      return n;
   endfunction

   // Greedy pass loop: fold in any row that strictly lowers the weight,
   // repeat full passes until one makes no change.
   function automatic rsp_word_type greedy_reduce(input logic [VEC_BITS-1:0] err);
      logic [VEC_BITS-1:0] vec;
      logic [VEC_BITS-1:0] trial;
      int                  weight;
      int                  w;
      int                  rows;
      bit                  improved;
      rsp_word_type        r;
      rows   = (model_active_rows > ROW_COUNT) ? ROW_COUNT : int'(model_active_rows);
      vec    = err;
      weight = ones_count(vec);
      do begin
         improved = 1'b0;
         for (int i = 0; i < rows; i++) begin
            trial = vec ^ model_rows[i];
            w     = ones_count(trial);
            if (w < weight) begin
               vec      = trial;
               weight   = w;
               improved = 1'b1;
            end
         end
      end while (improved);
      r.reduced_bits   = vec;
      r.reduced_weight = WEIGHT_BITS'(weight);
      return r;
   endfunction

   // Driver: present the next word at the falling edge once the previous one
   // was taken; idle at random about a fifth of the time unless in a steady stretch.
   always @(negedge clock) begin
      if (!start || took) begin
         if (cmd_queue.size() != 0 && (steady_run || $urandom_range(99) >= 20)) begin
            start    <= 1'b1;
            req_word <= cmd_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check the result first (it belongs to an older word), then
   // predict for a word taken at this edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (reduction_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result word: bits %h weight %0d",
                           rsp_word.reduced_bits, rsp_word.reduced_weight);
               end
            end else begin
               rsp_word_type want;
               want = reduction_queue.pop_front();
               if (rsp_word.reduced_bits !== want.reduced_bits) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("reduced_bits mismatch: expected %h actual %h",
                              want.reduced_bits, rsp_word.reduced_bits);
                  end
               end
               if (rsp_word.reduced_weight !== want.reduced_weight) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("reduced_weight mismatch: expected %0d actual %0d",
                              want.reduced_weight, rsp_word.reduced_weight);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (req_word.cmd == CMD_LOAD) begin
               // every 6-bit slot is inside the store, so a load always lands
               model_rows[req_word.row_slot] = req_word.row_bits;
            end else begin
               reduction_queue.push_back(greedy_reduce(req_word.error_bits));
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("tb_top failed");
      $finish;
   end

   // Hold until the driver is drained and every reduction has come back,
   // then wait on so that a trailing load can land.
   task automatic settle();
      while (cmd_queue.size() != 0 || start || reduction_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active_rows(input int unsigned value);
      @(negedge clock);
      csr_write_en      <= 1'b1;
      csr_write_data    <= CSR_BITS'(value);
      model_active_rows  = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   task automatic queue_load(input int slot, input logic [VEC_BITS-1:0] bits);
      req_word_type w;
      w.cmd        = CMD_LOAD;
      w.row_slot   = SLOT_BITS'(slot);
      w.row_bits   = bits;
      w.error_bits = {$urandom, $urandom};   // ignored by a load
      plan_rows[slot]   = bits;
      plan_loaded[slot] = 1'b1;
      cmd_queue.push_back(w);
      load_count++;
   endtask

   task automatic queue_reduce(input logic [VEC_BITS-1:0] err);
      req_word_type w;
      w.cmd        = CMD_REDUCE;
      w.row_slot   = SLOT_BITS'($urandom);   // ignored by a reduce
      w.row_bits   = {$urandom, $urandom};
      w.error_bits = err;
      cmd_queue.push_back(w);
      reduce_count++;
   endtask

   function automatic logic [VEC_BITS-1:0] sparse_bits(input int max_ones);
      logic [VEC_BITS-1:0] v;
      v = '0;
      repeat ($urandom_range(max_ones, 1)) v[$urandom_range(VEC_BITS - 1)] = 1'b1;
      return v;
   endfunction

   function automatic logic [VEC_BITS-1:0] row_pattern();
      int pick;
      pick = $urandom_range(9);
      if (pick <= 3) return {$urandom, $urandom};
      if (pick <= 6) return sparse_bits(6);
      if (pick == 7) return ~sparse_bits(4);
      if (pick == 8) return '0;
      return '1;
   endfunction

   // When rows are in use, half are sums of a few loaded rows plus light noise,
   // so that passes actually find cycles to strip; the rest are loose vectors.
   function automatic logic [VEC_BITS-1:0] error_pattern(input int rows);
      logic [VEC_BITS-1:0] v;
      int                  pick;
      pick = $urandom_range(9);
      if (rows > 0 && pick <= 4) begin
         v = '0;
         repeat ($urandom_range(4, 1)) v ^= plan_rows[$urandom_range(rows - 1)];
         if ($urandom_range(3) != 0) v ^= sparse_bits(3);
         return v;
      end
      if (pick <= 6) return {$urandom, $urandom};
      if (pick == 7) return sparse_bits(5);
      if (pick == 8) return '0;
      return '1;
   endfunction

   // One setting of active_rows: load any row it would read that is still
   // unwritten, then mix reloads with reductions.
   task automatic run_phase(input int unsigned setting, input int words,
                            input bit steady, input bit pause_midway);
      int rows;
      settle();
      write_active_rows(setting);
      steady_run = steady;
      rows = (setting > ROW_COUNT) ? ROW_COUNT : int'(setting);
      for (int i = 0; i < rows; i++) begin
         if (!plan_loaded[i]) queue_load(i, row_pattern());
      end
      for (int k = 0; k < words; k++) begin
         if (pause_midway && k == words / 2) settle();
         if ($urandom_range(3) == 0) begin
            queue_load($urandom_range(ROW_COUNT - 1), row_pattern());
         end else begin
            queue_reduce(error_pattern(rows));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ROW_COUNT; i++) plan_loaded[i] = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No rows in use after reset: vectors come back untouched.
      queue_reduce('0);
      queue_reduce('1);
      queue_reduce(64'hA5A5_5A5A_F00F_0FF0);
      queue_load(0, '1);
      queue_load(1, 64'h1);
      queue_load(2, '0);
      queue_load(3, 64'h3);
      queue_load(4, 64'h8000_0000_0000_0000);
      queue_load(63, {$urandom, $urandom});
      queue_reduce({$urandom, $urandom});
      settle();

      // Small hand-built store: full cancel, single bit, ties that must not
      // fold, and a two-step walk to zero across one pass.
      write_active_rows(5);
      queue_reduce('1);
      queue_reduce(64'h1);
      queue_reduce(64'h2);
      queue_reduce(64'h3);
      queue_reduce(64'h7);
      queue_reduce(64'h8000_0000_0000_0001);
      queue_reduce(64'hFFFF_FFFF_FFFF_FFFE);
      queue_reduce(64'h7FFF_FFFF_FFFF_FFFF);
      queue_reduce('0);

      // Random settings, clamp values above the store size among them.
      run_phase(1, 8, 1'b0, 1'b0);
      run_phase(64, 10, 1'b0, 1'b1);
      run_phase(127, 8, 1'b0, 1'b0);
      run_phase($urandom_range(16, 2), 14, 1'b1, 1'b0);
      run_phase(0, 6, 1'b0, 1'b0);
      run_phase(65, 8, 1'b0, 1'b0);
      run_phase($urandom_range(64, 1), 10, 1'b0, 1'b0);
      run_phase(3, 8, 1'b0, 1'b0);
      settle();

      $display("covered %0d row loads and %0d reductions (%0d results) over %0d",
               load_count, reduce_count, result_count, setting_count);
      $display("active_rows settings from 0 through 127, with drained pauses and gaps");
      if (mismatch_count == 0 && reduction_queue.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, reduction_queue.size());
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
